### sv/paged_knob_soft_takeover_core_macros.svh
// Assertion macros shared by the paged knob soft takeover RTL.
`ifndef PAGED_KNOB_SOFT_TAKEOVER_CORE_MACROS_SVH
`define PAGED_KNOB_SOFT_TAKEOVER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while arst_n is low.
`define PKST_ASSERT_IMP(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off while arst_n is low.
`define PKST_ASSERT_NXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

### sv/pkst_pkg.sv
// Package with the constants, codes and types of the paged knob soft takeover block.
package pkst_pkg;

	// Fixed shape of the channels and the page store.
	localparam int SLOTS           = 6;
	localparam int PAGES           = 2;
	localparam int FIELD_BITS      = 12;
	localparam int TOL_BITS        = 12;
	localparam int KNOB_COUNT_DEF  = 6;
	localparam int SAMPLE_BITS_DEF = 12;

	// Catch tolerance after reset.
	localparam logic [TOL_BITS-1:0] TOL_RESET = 12'd41;

	// Register indexes of the configuration port.
	localparam logic REG_CATCH_TOL = 1'b0;

	// Lock direction codes.
	localparam logic [1:0] LOCK_NONE  = 2'd0;
	localparam logic [1:0] LOCK_ABOVE = 2'd1;
	localparam logic [1:0] LOCK_BELOW = 2'd2;

	// Caught flag and lock direction of one knob on one page.
	typedef struct packed {
		logic       caught;
		logic [1:0] lock;
	} knob_flags_t;

	// One result beat as it sits in the output buffer.
	typedef struct packed {
		logic                             page_index;
		logic                             is_active;
		logic [SLOTS-1:0][FIELD_BITS-1:0] value;
		logic [SLOTS-1:0]                 caught_mask;
		logic                             last_of_run;
	} result_t;

endpackage

### sv/pkst_ifs.sv
// Valid/ready channel interfaces for knob samples and page results.
interface pkst_in_if;
	logic                           valid;
	logic                           ready;
	logic [pkst_pkg::FIELD_BITS-1:0] knob0;
	logic [pkst_pkg::FIELD_BITS-1:0] knob1;
	logic [pkst_pkg::FIELD_BITS-1:0] knob2;
	logic [pkst_pkg::FIELD_BITS-1:0] knob3;
	logic [pkst_pkg::FIELD_BITS-1:0] knob4;
	logic [pkst_pkg::FIELD_BITS-1:0] knob5;
	logic                           page_press;

	modport source (output valid, knob0, knob1, knob2, knob3, knob4, knob5, page_press,
		input ready);
	modport sink (input valid, knob0, knob1, knob2, knob3, knob4, knob5, page_press,
		output ready);
endinterface

interface pkst_out_if;
	logic                           valid;
	logic                           ready;
	logic                           page_index;
	logic                           is_active;
	logic [pkst_pkg::FIELD_BITS-1:0] value0;
	logic [pkst_pkg::FIELD_BITS-1:0] value1;
	logic [pkst_pkg::FIELD_BITS-1:0] value2;
	logic [pkst_pkg::FIELD_BITS-1:0] value3;
	logic [pkst_pkg::FIELD_BITS-1:0] value4;
	logic [pkst_pkg::FIELD_BITS-1:0] value5;
	logic [pkst_pkg::SLOTS-1:0]      caught_mask;
	logic                           last_of_run;

	modport source (output valid, page_index, is_active, value0, value1, value2, value3,
		value4, value5, caught_mask, last_of_run, input ready);
	modport sink (input valid, page_index, is_active, value0, value1, value2, value3,
		value4, value5, caught_mask, last_of_run, output ready);
endinterface

### sv/paged_knob_soft_takeover_core.sv
// Top level of the paged knob soft takeover block.
//
// Samples arrive on the sample channel: six knob readings and a page-button event per
// beat. Each accepted sample goes into an input register; from there the six knob
// lanes update the active page (toggled first when page_press is set) when the result
// buffer can take the pair; the two page reports go into it in the same edge.
// The result channel then carries two beats per sample: page 0, then page 1 with
// last_of_run set. A sample passes the input register and then the result buffer.
// Throughput is set by the two beats that each sample sends over the single result
// channel; the lanes themselves take one sample a cycle. A new sample is taken while
// the second beat of the previous one is being delivered. When the receiver stalls,
// the buffer holds its beat, the input register fills and sample.ready drops until
// the buffer drains.
// Reset (arst_n low) restores the default page values, marks every knob caught with no
// lock, selects page 0 and sets the catch tolerance to 41. The tolerance is register
// 0 of the APB port at byte address 0 and should be written while the block is idle.
module paged_knob_soft_takeover_core #(
	parameter int KNOB_COUNT  = pkst_pkg::KNOB_COUNT_DEF,
	parameter int SAMPLE_BITS = pkst_pkg::SAMPLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pkst_in_if.sink     sample,
	pkst_out_if.source  result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SB    = SAMPLE_BITS;
	localparam int KC    = KNOB_COUNT;
	localparam int FB    = pkst_pkg::FIELD_BITS;
	localparam int SL    = pkst_pkg::SLOTS;
	localparam int NP    = pkst_pkg::PAGES;
	localparam int FULL  = (1 << SB) - 1;
	localparam int T_DEF = (FULL * 61 + 50) / 100;
	localparam int F_DEF = (FULL * 30 + 50) / 100;
	localparam int M_DEF = (FULL + 1) / 2;

	logic [pkst_pkg::TOL_BITS-1:0] tol;
	logic [FB-1:0]                 knob_w [SL];

	logic                          v_s1;
	logic [SB-1:0]                 rd_s1 [KC];
	logic                          press_s1;

	logic [SB-1:0]                 stored_q [NP][KC];
	pkst_pkg::knob_flags_t         flags_q  [NP][KC];
	logic                          active_q;

	logic                          new_page;
	logic [SB-1:0]                 nxt_stored [KC];
	pkst_pkg::knob_flags_t         nxt_flags  [KC];
	pkst_pkg::result_t             pair [NP];
	logic                          can_load;
	logic                          load;

	pkst_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.tol     (tol)
	);

	assign knob_w[0] = sample.knob0;
	assign knob_w[1] = sample.knob1;
	assign knob_w[2] = sample.knob2;
	assign knob_w[3] = sample.knob3;
	assign knob_w[4] = sample.knob4;
	assign knob_w[5] = sample.knob5;

	// The input register moves on whenever the result buffer can take its pair.
	assign load         = v_s1 && can_load;
	assign sample.ready = !v_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (sample.ready) begin
			v_s1 <= sample.valid;
		end
	end

	// Sample payload, cut to the working sample width.
	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			for (int k = 0; k < KC; k++) begin
				rd_s1[k] <= SB'(knob_w[k]);
			end
			press_s1 <= sample.page_press;
		end
	end

	// A press switches the page before the lanes run.
	assign new_page = active_q ^ press_s1;

	for (genvar k = 0; k < KC; k++) begin : g_lane
		pkst_lane #(
			.SAMPLE_BITS (SB)
		) u_lane (
			.reading    (rd_s1[k]),
			.stored     (stored_q[new_page][k]),
			.flags      (flags_q[new_page][k]),
			.tol        (tol),
			.press      (press_s1),
			.nxt_stored (nxt_stored[k]),
			.nxt_flags  (nxt_flags[k])
		);
	end

	// Page store: only the page being updated is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			for (int p = 0; p < NP; p++) begin
				for (int k = 0; k < KC; k++) begin
					flags_q[p][k].caught <= 1'b1;
					flags_q[p][k].lock   <= pkst_pkg::LOCK_NONE;
					if (p != 0) begin
						stored_q[p][k] <= '0;
					end else if (k < 2) begin
						stored_q[p][k] <= SB'(T_DEF);
					end else if (k < 4) begin
						stored_q[p][k] <= SB'(F_DEF);
					end else begin
						stored_q[p][k] <= SB'(M_DEF);
					end
				end
			end
		end else if (load) begin
			active_q <= new_page;
			for (int k = 0; k < KC; k++) begin
				stored_q[new_page][k] <= nxt_stored[k];
				flags_q[new_page][k]  <= nxt_flags[k];
			end
		end
	end

	// Both page reports, taken from the state as it stands after this sample.
	for (genvar p = 0; p < NP; p++) begin : g_page
		logic upd;
		assign upd                = (new_page == 1'(p));
		assign pair[p].page_index = 1'(p);
		assign pair[p].is_active  = upd;
		assign pair[p].last_of_run = (p == NP - 1);
		for (genvar k = 0; k < SL; k++) begin : g_slot
			if (k < KC) begin : g_used
				logic [SB-1:0] st;
				assign st                     = upd ? nxt_stored[k] : stored_q[p][k];
				assign pair[p].value[k]       = FB'(st);
				assign pair[p].caught_mask[k] = upd ? nxt_flags[k].caught
					: flags_q[p][k].caught;
			end else begin : g_unused
				assign pair[p].value[k]       = '0;
				assign pair[p].caught_mask[k] = 1'b0;
			end
		end
	end

	pkst_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.pair     (pair),
		.can_load (can_load),
		.result   (result)
	);

endmodule

### sv/pkst_apb.sv
// APB-style configuration port holding the catch tolerance register.
module pkst_apb (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [2:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output logic [pkst_pkg::TOL_BITS-1:0]  tol
);

	localparam int TB = pkst_pkg::TOL_BITS;

	logic [TB-1:0] tol_q;
	logic          reg_idx;
	logic          wr_en;

	// Registers sit on 32-bit words, so the word index is the top address bit.
	assign reg_idx = paddr[2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	// Register write on the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= pkst_pkg::TOL_RESET;
		end else if (wr_en && (reg_idx == pkst_pkg::REG_CATCH_TOL)) begin
			tol_q <= pwdata[TB-1:0];
		end
	end

	// Read decode; addresses past the register list read as zero.
	always_comb begin
		unique case (reg_idx)
			pkst_pkg::REG_CATCH_TOL: prdata = 32'(tol_q);
			default:                 prdata = '0;
		endcase
	end

	assign tol = tol_q;

endmodule

### sv/pkst_lane.sv
// Soft takeover decision for one knob on the page being updated.
module pkst_lane #(
	parameter int SAMPLE_BITS = pkst_pkg::SAMPLE_BITS_DEF
) (
	input  logic [SAMPLE_BITS-1:0]          reading,
	input  logic [SAMPLE_BITS-1:0]          stored,
	input  pkst_pkg::knob_flags_t           flags,
	input  logic [pkst_pkg::TOL_BITS-1:0]   tol,
	input  logic                            press,
	output logic [SAMPLE_BITS-1:0]          nxt_stored,
	output pkst_pkg::knob_flags_t           nxt_flags
);

	localparam int TB = pkst_pkg::TOL_BITS;
	localparam int CW = (SAMPLE_BITS > TB) ? SAMPLE_BITS : TB;

	logic                   above;
	logic [SAMPLE_BITS-1:0] diff;
	logic [CW-1:0]          diff_w;
	logic [CW-1:0]          tol_w;
	logic                   in_tol;
	logic [1:0]             side;
	logic                   crossed;

	// Distance from the stored value and the side the reading lies on.
	assign above   = reading > stored;
	assign diff    = above ? (reading - stored) : (stored - reading);
	assign diff_w  = CW'(diff);
	assign tol_w   = CW'(tol);
	assign in_tol  = diff_w <= tol_w;
	assign side    = above ? pkst_pkg::LOCK_ABOVE : pkst_pkg::LOCK_BELOW;
	assign crossed = (flags.lock != pkst_pkg::LOCK_NONE) && (flags.lock != side);

	// A page change re-evaluates the knob; otherwise a caught knob tracks its reading
	// and a locked one waits to come within tolerance or to cross its stored value.
	always_comb begin
		nxt_stored = stored;
		nxt_flags  = flags;
		if (press) begin
			if (in_tol) begin
				nxt_stored       = reading;
				nxt_flags.caught = 1'b1;
				nxt_flags.lock   = pkst_pkg::LOCK_NONE;
			end else begin
				nxt_flags.caught = 1'b0;
				nxt_flags.lock   = side;
			end
		end else if (flags.caught || in_tol || crossed) begin
			nxt_stored       = reading;
			nxt_flags.caught = 1'b1;
		end
	end

endmodule

### sv/pkst_out.sv
// Result buffer that sends the two page results of one sample as two beats.
`include "paged_knob_soft_takeover_core_macros.svh"

module pkst_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  pkst_pkg::result_t pair [pkst_pkg::PAGES],
	output logic              can_load,
	pkst_out_if.source        result
);

	pkst_pkg::result_t res_q [pkst_pkg::PAGES];
	pkst_pkg::result_t cur;
	logic              full_q;
	logic              phase_q;
	logic              beat;

	assign beat     = full_q && result.ready;
	// The buffer frees up as the second beat leaves, so a new pair can follow at once.
	assign can_load = !full_q || (result.ready && phase_q);

	// Occupancy and which of the two beats is on offer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			full_q  <= 1'b1;
			phase_q <= 1'b0;
		end else if (beat) begin
			if (phase_q) begin
				full_q  <= 1'b0;
				phase_q <= 1'b0;
			end else begin
				phase_q <= 1'b1;
			end
		end
	end

	// Payload of both beats, captured together.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= pair;
		end
	end

	assign cur = phase_q ? res_q[1] : res_q[0];

	assign result.valid       = full_q;
	assign result.page_index  = cur.page_index;
	assign result.is_active   = cur.is_active;
	assign result.value0      = cur.value[0];
	assign result.value1      = cur.value[1];
	assign result.value2      = cur.value[2];
	assign result.value3      = cur.value[3];
	assign result.value4      = cur.value[4];
	assign result.value5      = cur.value[5];
	assign result.caught_mask = cur.caught_mask;
	assign result.last_of_run = cur.last_of_run;

	`PKST_ASSERT_NXT(a_second_beat_follows, beat && !phase_q, full_q && phase_q && result.page_index, "first beat was not followed by the second page")
	`PKST_ASSERT_IMP(a_no_overwrite, load, !full_q || (result.ready && phase_q), "result pair loaded over beats still waiting")
	`PKST_ASSERT_IMP(a_one_active_page, full_q, res_q[0].is_active != res_q[1].is_active, "buffered pair does not mark exactly one active page")

endmodule

### tb/paged_knob_soft_takeover_core_tb.sv
// Self-checking testbench for the paged knob soft takeover core: directed table, then random phases.
module paged_knob_soft_takeover_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS      = pkst_pkg::SLOTS;
	localparam int PAGES      = pkst_pkg::PAGES;
	localparam int FIELD_BITS = pkst_pkg::FIELD_BITS;
	localparam int TOL_BITS   = pkst_pkg::TOL_BITS;

	localparam int NDIR        = 17;
	localparam int NPHASE      = 5;
	localparam int PHASE_ITEMS = 130;
	localparam int QUIET_LIMIT = 1000;
	localparam int SETTLE      = 8;

	// Byte address of the tolerance register, four bytes per register.
	localparam logic [2:0] TOL_ADDR = {pkst_pkg::REG_CATCH_TOL, 2'b00};

	localparam logic [SLOTS-1:0][FIELD_BITS-1:0] ALL_LOW  = {SLOTS{12'd0}};
	localparam logic [SLOTS-1:0][FIELD_BITS-1:0] ALL_HIGH = {SLOTS{12'hFFF}};
	localparam logic [SLOTS-1:0][FIELD_BITS-1:0] ALL_MID  = {SLOTS{12'd2048}};
	localparam logic [SLOTS-1:0]                 NO_KNOBS  = 6'h00;
	localparam logic [SLOTS-1:0]                 ALL_KNOBS = 6'h3F;

	// One row of stimulus. Where typed is set, both page reports are given outright.
	typedef struct packed {
		logic                             retune;
		logic [TOL_BITS-1:0]              tol;
		logic [SLOTS-1:0][FIELD_BITS-1:0] knobs;
		logic                             press;
		logic                             typed;
		logic                             active_pg;
		logic [SLOTS-1:0][FIELD_BITS-1:0] val0;
		logic [SLOTS-1:0]                 mask0;
		logic [SLOTS-1:0][FIELD_BITS-1:0] val1;
		logic [SLOTS-1:0]                 mask1;
	} knob_row_t;

	// Directed rows; knob values in a concatenation run from knob5 down to knob0.
	knob_row_t dir_rows [NDIR] = '{
		// Reset state: every knob caught, so the first page simply follows the knobs.
		'{1'b0, 12'd0, ALL_LOW, 1'b0, 1'b1, 1'b0, ALL_LOW, ALL_KNOBS, ALL_LOW, ALL_KNOBS},
		'{1'b0, 12'd0, ALL_HIGH, 1'b0, 1'b1, 1'b0, ALL_HIGH, ALL_KNOBS, ALL_LOW, ALL_KNOBS},
		// Press onto the second page with equal readings: caught at once.
		'{1'b0, 12'd0, ALL_LOW, 1'b1, 1'b1, 1'b1, ALL_HIGH, ALL_KNOBS, ALL_LOW, ALL_KNOBS},
		// Press back with readings at the far end: every knob locked below.
		'{1'b0, 12'd0, ALL_LOW, 1'b1, 1'b1, 1'b0, ALL_HIGH, NO_KNOBS, ALL_LOW, ALL_KNOBS},
		// Readings return to the stored value and catch.
		'{1'b0, 12'd0, ALL_HIGH, 1'b0, 1'b1, 1'b0, ALL_HIGH, ALL_KNOBS, ALL_LOW, ALL_KNOBS},
		'{1'b0, 12'd0, ALL_MID, 1'b0, 1'b0, 1'b0, ALL_LOW, NO_KNOBS, ALL_LOW, NO_KNOBS},
		// Locked above on the second page, then a move on the same side stays frozen.
		'{1'b0, 12'd0, ALL_MID, 1'b1, 1'b0, 1'b0, ALL_LOW, NO_KNOBS, ALL_LOW, NO_KNOBS},
		'{1'b0, 12'd0, {SLOTS{12'd1000}}, 1'b0, 1'b0, 1'b0, ALL_LOW, NO_KNOBS, ALL_LOW, NO_KNOBS},
		// Tolerance edges: a distance of 41 catches, 42 does not.
		'{1'b0, 12'd0, {12'd2048, 12'd4095, 12'd0, 12'd40, 12'd42, 12'd41},
			1'b0, 1'b0, 1'b0, ALL_LOW, NO_KNOBS, ALL_LOW, NO_KNOBS},
		'{1'b0, 12'd0, {12'd0, 12'd2048, 12'd2006, 12'd2090, 12'd2007, 12'd2089},
			1'b1, 1'b0, 1'b0, ALL_LOW, NO_KNOBS, ALL_LOW, NO_KNOBS},
		// Locked knobs cross over their stored value and catch.
		'{1'b0, 12'd0, {12'd4095, 12'd2048, 12'd2200, 12'd1900, 12'd2048, 12'd2048},
			1'b0, 1'b0, 1'b0, ALL_LOW, NO_KNOBS, ALL_LOW, NO_KNOBS},
		// Tolerance of zero: only an exact match or a crossing catches.
		'{1'b1, 12'd0, {12'd1, 12'd0, 12'd0, 12'd0, 12'd41, 12'd41},
			1'b1, 1'b0, 1'b0, ALL_LOW, NO_KNOBS, ALL_LOW, NO_KNOBS},
		'{1'b0, 12'd0, {12'd1, 12'd0, 12'd0, 12'd0, 12'd39, 12'd42},
			1'b0, 1'b0, 1'b0, ALL_LOW, NO_KNOBS, ALL_LOW, NO_KNOBS},
		'{1'b0, 12'd0, {12'd0, 12'd0, 12'd0, 12'd41, 12'd0, 12'd42},
			1'b0, 1'b0, 1'b0, ALL_LOW, NO_KNOBS, ALL_LOW, NO_KNOBS},
		// Widest tolerance: every knob is caught on a press.
		'{1'b1, 12'hFFF, ALL_HIGH, 1'b1, 1'b0, 1'b0, ALL_LOW, NO_KNOBS, ALL_LOW, NO_KNOBS},
		'{1'b0, 12'd0, ALL_LOW, 1'b1, 1'b1, 1'b1, ALL_HIGH, ALL_KNOBS, ALL_LOW, ALL_KNOBS},
		'{1'b0, 12'd0, ALL_HIGH, 1'b0, 1'b0, 1'b0, ALL_LOW, NO_KNOBS, ALL_LOW, NO_KNOBS}
	};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	pkst_in_if  sample_ch ();
	pkst_out_if result_ch ();

	paged_knob_soft_takeover_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Own copy of the page store, flags and tolerance.
	logic [SLOTS-1:0][FIELD_BITS-1:0] pg_val    [PAGES];
	logic [SLOTS-1:0]                 pg_caught [PAGES];
	logic [SLOTS-1:0][1:0]            pg_lock   [PAGES];
	logic                             act_page;
	logic [TOL_BITS-1:0]              catch_tol;

	// Page reports still owed by the block, oldest first.
	pkst_pkg::result_t page_reports_due [$];

	bit idle_on;
	int fails;
	int samples_sent;
	int beats_checked;
	int presses;
	int cross_catches;
	int tol_catches;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advance the page model by one sample; push both page reports when asked to.
	function automatic void takeover_step(input logic [SLOTS-1:0][FIELD_BITS-1:0] rd,
			input logic press, input logic push);
		logic [FIELD_BITS-1:0] st;
		logic [FIELD_BITS-1:0] gap;
		logic [1:0]            side;
		pkst_pkg::result_t     rep;
		// A press flips the page and either catches or locks every knob on it.
		if (press) begin
			act_page = ~act_page;
			presses++;
			for (int k = 0; k < SLOTS; k++) begin
				st  = pg_val[act_page][k];
				gap = (rd[k] > st) ? rd[k] - st : st - rd[k];
				if (gap <= catch_tol) begin
					pg_caught[act_page][k] = 1'b1;
					pg_lock[act_page][k]   = pkst_pkg::LOCK_NONE;
					pg_val[act_page][k]    = rd[k];
				end else begin
					pg_caught[act_page][k] = 1'b0;
					pg_lock[act_page][k]   = (rd[k] > st) ? pkst_pkg::LOCK_ABOVE
						: pkst_pkg::LOCK_BELOW;
				end
			end
		end
		// Caught knobs follow their readings; locked ones wait for a catch or a crossing.
		for (int k = 0; k < SLOTS; k++) begin
			st   = pg_val[act_page][k];
			gap  = (rd[k] > st) ? rd[k] - st : st - rd[k];
			side = (rd[k] > st) ? pkst_pkg::LOCK_ABOVE : pkst_pkg::LOCK_BELOW;
			if (pg_caught[act_page][k]) begin
				pg_val[act_page][k] = rd[k];
			end else if (gap <= catch_tol) begin
				pg_caught[act_page][k] = 1'b1;
				pg_val[act_page][k]    = rd[k];
				tol_catches++;
			end else if (pg_lock[act_page][k] != pkst_pkg::LOCK_NONE
					&& pg_lock[act_page][k] != side) begin
				pg_caught[act_page][k] = 1'b1;
				pg_val[act_page][k]    = rd[k];
				cross_catches++;
			end
		end
		if (push) begin
			for (int p = 0; p < PAGES; p++) begin
				rep.page_index  = p[0];
				rep.is_active   = (act_page == p[0]);
				rep.value       = pg_val[p];
				rep.caught_mask = pg_caught[p];
				rep.last_of_run = (p == PAGES - 1);
				page_reports_due.push_back(rep);
			end
		end
	endfunction

	function automatic void check_field(input string name, input logic [FIELD_BITS-1:0] want,
			input logic [FIELD_BITS-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endfunction

	// Offer one sample, after an optional gap, and hold it until the block takes it.
	task automatic send_sample(input knob_row_t r);
		pkst_pkg::result_t rep;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		sample_ch.valid      <= 1'b1;
		sample_ch.knob0      <= r.knobs[0];
		sample_ch.knob1      <= r.knobs[1];
		sample_ch.knob2      <= r.knobs[2];
		sample_ch.knob3      <= r.knobs[3];
		sample_ch.knob4      <= r.knobs[4];
		sample_ch.knob5      <= r.knobs[5];
		sample_ch.page_press <= r.press;
		do @(posedge clk); while (!sample_ch.ready);
		samples_sent++;
		takeover_step(r.knobs, r.press, !r.typed);
		// Rows with reports typed in are checked against those instead.
		if (r.typed) begin
			for (int p = 0; p < PAGES; p++) begin
				rep.page_index  = p[0];
				rep.is_active   = (r.active_pg == p[0]);
				rep.value       = (p == 0) ? r.val0 : r.val1;
				rep.caught_mask = (p == 0) ? r.mask0 : r.mask1;
				rep.last_of_run = (p == PAGES - 1);
				page_reports_due.push_back(rep);
			end
		end
	endtask

	// Stop sending and let every owed report come out, plus the block's latency.
	task automatic drain_reports();
		sample_ch.valid <= 1'b0;
		while (page_reports_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the catch tolerance over the APB port and read it back.
	task automatic write_tolerance(input logic [TOL_BITS-1:0] tol);
		logic [31:0] readback;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= TOL_ADDR;
		pwdata  <= {20'd0, tol};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		catch_tol = tol;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback !== {20'd0, tol}) begin
			$error("catch_tolerance readback: expected %0d, got %0d", tol, readback);
			fails++;
		end
	endtask

	// Receiver side: ready drops in random bursts while idling is on.
	initial begin : result_stalls
		int stall_left;
		stall_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				result_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 4);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each result beat with the oldest owed page report.
	always @(posedge clk) begin : report_check
		pkst_pkg::result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			beats_checked++;
			if (page_reports_due.size() == 0) begin
				$error("result beat for page %0d arrived with no report owed",
					result_ch.page_index);
				fails++;
			end else begin
				want = page_reports_due.pop_front();
				check_field("page_index", FIELD_BITS'(want.page_index),
					FIELD_BITS'(result_ch.page_index));
				check_field("is_active", FIELD_BITS'(want.is_active),
					FIELD_BITS'(result_ch.is_active));
				check_field("value0", want.value[0], result_ch.value0);
				check_field("value1", want.value[1], result_ch.value1);
				check_field("value2", want.value[2], result_ch.value2);
				check_field("value3", want.value[3], result_ch.value3);
				check_field("value4", want.value[4], result_ch.value4);
				check_field("value5", want.value[5], result_ch.value5);
				check_field("caught_mask", FIELD_BITS'(want.caught_mask),
					FIELD_BITS'(result_ch.caught_mask));
				check_field("last_of_run", FIELD_BITS'(want.last_of_run),
					FIELD_BITS'(result_ch.last_of_run));
			end
		end
	end

	// Watchdog: too long without a beat on either channel ends the run.
	always @(posedge clk) begin
		if (!arst_n || (sample_ch.valid && sample_ch.ready)
				|| (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("paged_knob_soft_takeover_core: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int                  hand [SLOTS];
		int                  roll;
		int                  st;
		logic [TOL_BITS-1:0] phase_tol [NPHASE];
		knob_row_t           row;

		// Every input at a known value from the start.
		arst_n               <= 1'b0;
		psel                 <= 1'b0;
		penable              <= 1'b0;
		pwrite               <= 1'b0;
		paddr                <= '0;
		pwdata               <= '0;
		sample_ch.valid      <= 1'b0;
		sample_ch.knob0      <= '0;
		sample_ch.knob1      <= '0;
		sample_ch.knob2      <= '0;
		sample_ch.knob3      <= '0;
		sample_ch.knob4      <= '0;
		sample_ch.knob5      <= '0;
		sample_ch.page_press <= 1'b0;

		// Model state after reset.
		pg_val[0]    = {12'd2048, 12'd2048, 12'd1229, 12'd1229, 12'd2498, 12'd2498};
		pg_val[1]    = ALL_LOW;
		pg_caught[0] = ALL_KNOBS;
		pg_caught[1] = ALL_KNOBS;
		pg_lock[0]   = '0;
		pg_lock[1]   = '0;
		act_page     = 1'b0;
		catch_tol    = pkst_pkg::TOL_RESET;
		idle_on      = 1'b1;
		for (int k = 0; k < SLOTS; k++) hand[k] = 2048;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, retuning the tolerance where a row asks for it.
		for (int i = 0; i < NDIR; i++) begin
			if (dir_rows[i].retune) begin
				drain_reports();
				write_tolerance(dir_rows[i].tol);
			end
			send_sample(dir_rows[i]);
		end

		// Random phases, each at its own tolerance; the last one runs without idling.
		phase_tol[0] = 12'($urandom_range(1, 200));
		phase_tol[1] = 12'd0;
		phase_tol[2] = 12'hFFF;
		phase_tol[3] = pkst_pkg::TOL_RESET;
		phase_tol[4] = 12'($urandom_range(0, 4095));
		for (int ph = 0; ph < NPHASE; ph++) begin
			drain_reports();
			write_tolerance(phase_tol[ph]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0)
					idle_on = (ph != NPHASE - 1) && ($urandom_range(0, 2) != 0);
				// Once, hold the sender back until every owed report has come.
				if (ph == 1 && n == PHASE_ITEMS / 2)
					drain_reports();
				row = '0;
				// Mostly slow hand movement, so knobs lock, cross and catch again.
				for (int k = 0; k < SLOTS; k++) begin
					roll = $urandom_range(0, 99);
					st   = int'(pg_val[act_page][k]);
					if (roll < 70)
						hand[k] = hand[k] + $urandom_range(0, 160) - 80;
					else if (roll < 82)
						hand[k] = $urandom_range(0, 4095);
					else if (roll < 88)
						hand[k] = $urandom_range(0, 1) ? 4095 : 0;
					else if (roll < 94)
						hand[k] = st;
					else if (roll < 97)
						hand[k] = st + int'(catch_tol) + $urandom_range(0, 1);
					else
						hand[k] = st - int'(catch_tol) - $urandom_range(0, 1);
					if (hand[k] < 0) hand[k] = 0;
					if (hand[k] > 4095) hand[k] = 4095;
					row.knobs[k] = 12'(hand[k]);
				end
				row.press = ($urandom_range(0, 9) == 0);
				send_sample(row);
			end
		end
		sample_ch.valid <= 1'b0;

		// Let the last reports out, then watch a little longer for stray beats.
		while (page_reports_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d samples with %0d page presses; checked %0d page report beats.",
			samples_sent, presses, beats_checked);
		$display("Tolerances 0, 41, 4095 and random; %0d catches by tolerance, %0d by crossing.",
			tol_catches, cross_catches);
		if (fails == 0)
			$display("paged_knob_soft_takeover_core: match");
		else
			$display("paged_knob_soft_takeover_core: mismatch");
		$finish;
	end

endmodule
